// File: rtl/cfol_pkg.sv
// ----------------------------------------------------------------------------
// CAN frame overwrite log: shared types and constants
// Request and response layouts, command and status codes, and the layout of
// one stored log entry.
// ----------------------------------------------------------------------------
package cfol_pkg;

    // Largest data length code that an append may carry.
    localparam int MAX_PAYLOAD = 8;
    localparam logic [3:0] DLC_LIMIT = 4'(MAX_PAYLOAD);

    // Command codes.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Port codes; an append with either of the other two codes is rejected.
    localparam logic [1:0] PORT_ONE = 2'd0;
    localparam logic [1:0] PORT_TWO = 2'd1;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PORT  = 2'd1;
    localparam logic [1:0] ST_BAD_DLC   = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    // One command as it arrives.
    typedef struct packed {
        logic        cmd;
        logic [1:0]  port;
        logic [28:0] frame_id;
        logic        extended;
        logic [3:0]  dlc;
        logic [31:0] data_low;
        logic [31:0] data_high;
        logic [5:0]  index;
    } req_t;

    // One result as it leaves.
    typedef struct packed {
        logic [1:0]  status;
        logic        rd_port;
        logic [28:0] rd_frame_id;
        logic        rd_extended;
        logic [3:0]  rd_dlc;
        logic [31:0] rd_data_low;
        logic [31:0] rd_data_high;
        logic [6:0]  entry_count;
        logic [31:0] dropped_total;
        logic [31:0] port1_total;
        logic [31:0] port2_total;
    } rsp_t;

    // One frame as it is held in the log memory.
    typedef struct packed {
        logic        port;
        logic [3:0]  dlc;
        logic        extended;
        logic [28:0] frame_id;
        logic [31:0] data_high;
        logic [31:0] data_low;
    } entry_t;

endpackage

// File: rtl/cfol_entry_ram.sv
// ----------------------------------------------------------------------------
// CAN frame overwrite log: entry memory
// Single-port synchronous memory of log entries with a registered read port.
// ----------------------------------------------------------------------------
module cfol_entry_ram #(
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic                                     wr,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  cfol_pkg::entry_t                         wdata,
    output cfol_pkg::entry_t                         rdata
);

    cfol_pkg::entry_t mem [DEPTH];
    cfol_pkg::entry_t rdata_reg;

    // A write stores the entry; a read loads the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/can_frame_overwrite_log_unit.sv
// ----------------------------------------------------------------------------
// CAN frame overwrite log
// Ring log of received CAN frames that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// Usage:
// A request on req (valid/stall) either appends a frame or reads the entry at
// a position counted from the oldest one. Every request yields exactly one
// response on rsp (valid/stall) with a status, the read frame for a good
// read (zero otherwise), the entry count, the dropped total and the two
// per-port receive totals.
// Each request passes through an accept step and a result step: at the
// accepting edge the slot address is formed, the frame memory is written or
// read and the counters are updated; in the result step the registered memory
// data and the counters are loaded into the response register once it is
// free. Only then is a new request accepted, so the block does not take a new
// request until the last one has reached the response register.
// While the receiver stalls, the response register holds its contents; a
// request may still be accepted, and its result waits until the register is
// free. Reset empties the log and clears all counters; no memory sweep is
// needed, since only written entries can ever be read.
// ----------------------------------------------------------------------------
module can_frame_overwrite_log_unit #(
    parameter int LOG_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cfol_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cfol_pkg::rsp_t  rsp
);

    localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LOG_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(LOG_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(LOG_DEPTH - 1);

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   oldest_slot_reg, oldest_slot_next;
    logic [CNT_W-1:0]   held_count_reg, held_count_next;
    logic [31:0]        dropped_reg, dropped_next;
    logic [31:0]        port1_reg, port1_next;
    logic [31:0]        port2_reg, port2_next;
    logic [1:0]         status_reg, status_next;
    logic               rd_hit_reg, rd_hit_next;
    logic               rsp_valid_reg, rsp_valid_next;
    cfol_pkg::rsp_t     rsp_reg, rsp_next;

    logic               accept;
    logic               is_full;
    logic               port_bad;
    logic               dlc_bad;
    logic               idx_ok;
    logic [1:0]         status;
    logic               append_ok;
    logic [CNT_W-1:0]   offset;
    logic [SUM_W-1:0]   slot_sum;
    logic [PTR_W-1:0]   slot;
    logic               ram_en;
    cfol_pkg::entry_t   wr_entry;
    cfol_pkg::entry_t   rd_entry;

    // Requests are taken only when no earlier request is in flight.
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);

    // Checks on the incoming request.
    assign is_full  = (held_count_reg == DEPTH_CNT);
    assign port_bad = (req.port != cfol_pkg::PORT_ONE) && (req.port != cfol_pkg::PORT_TWO);
    assign dlc_bad  = (req.dlc > cfol_pkg::DLC_LIMIT);
    assign idx_ok   = (CMP_W'(req.index) < CMP_W'(held_count_reg));

    always_comb
    begin
        if (req.cmd == cfol_pkg::CMD_READ)
        begin
            status = idx_ok ? cfol_pkg::ST_OK : cfol_pkg::ST_BAD_INDEX;
        end
        else if (port_bad)
        begin
            status = cfol_pkg::ST_BAD_PORT;
        end
        else if (dlc_bad)
        begin
            status = cfol_pkg::ST_BAD_DLC;
        end
        else
        begin
            status = cfol_pkg::ST_OK;
        end
    end

    assign append_ok = accept && (req.cmd == cfol_pkg::CMD_APPEND) &&
                       (status == cfol_pkg::ST_OK);

    // Slot address: the oldest slot plus an offset, wrapped once. The sum
    // always stays below twice the depth for every access that reaches the memory.
    assign offset = (req.cmd == cfol_pkg::CMD_READ) ? CNT_W'(req.index) :
                    (is_full ? '0 : held_count_reg);
    assign slot_sum = SUM_W'(oldest_slot_reg) + SUM_W'(offset);
    assign slot = (slot_sum >= DEPTH_SUM) ? PTR_W'(slot_sum - DEPTH_SUM) : PTR_W'(slot_sum);

    // Frame memory access at the accepting edge.
    assign ram_en = append_ok ||
                    (accept && (req.cmd == cfol_pkg::CMD_READ) && idx_ok);

    assign wr_entry.port      = req.port[0];
    assign wr_entry.dlc       = req.dlc;
    assign wr_entry.extended  = req.extended;
    assign wr_entry.frame_id  = req.frame_id;
    assign wr_entry.data_high = req.data_high;
    assign wr_entry.data_low  = req.data_low;

    cfol_entry_ram #(
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .wr    (req.cmd == cfol_pkg::CMD_APPEND),
        .addr  (slot),
        .wdata (wr_entry),
        .rdata (rd_entry)
    );

    // Next-state logic for the sequencer, counters and response register.
    always_comb
    begin
        state_next       = state_reg;
        oldest_slot_next = oldest_slot_reg;
        held_count_next  = held_count_reg;
        dropped_next     = dropped_reg;
        port1_next       = port1_reg;
        port2_next       = port2_reg;
        status_next      = status_reg;
        rd_hit_next      = rd_hit_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_RESULT;
                    status_next = status;
                    rd_hit_next = (req.cmd == cfol_pkg::CMD_READ) && idx_ok;
                    if (append_ok)
                    begin
                        if (is_full)
                        begin
                            oldest_slot_next = (oldest_slot_reg == LAST_PTR) ?
                                               '0 : oldest_slot_reg + 1'b1;
                            dropped_next     = dropped_reg + 32'd1;
                        end
                        else
                        begin
                            held_count_next = held_count_reg + 1'b1;
                        end
                        if (req.port == cfol_pkg::PORT_ONE)
                        begin
                            port1_next = port1_reg + 32'd1;
                        end
                        else
                        begin
                            port2_next = port2_reg + 32'd1;
                        end
                    end
                end
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.rd_port       = rd_hit_reg ? rd_entry.port : 1'b0;
                    rsp_next.rd_frame_id   = rd_hit_reg ? rd_entry.frame_id : '0;
                    rsp_next.rd_extended   = rd_hit_reg ? rd_entry.extended : 1'b0;
                    rsp_next.rd_dlc        = rd_hit_reg ? rd_entry.dlc : '0;
                    rsp_next.rd_data_low   = rd_hit_reg ? rd_entry.data_low : '0;
                    rsp_next.rd_data_high  = rd_hit_reg ? rd_entry.data_high : '0;
                    rsp_next.entry_count   = 7'(held_count_reg);
                    rsp_next.dropped_total = dropped_reg;
                    rsp_next.port1_total   = port1_reg;
                    rsp_next.port2_total   = port2_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            oldest_slot_reg <= '0;
            held_count_reg  <= '0;
            dropped_reg     <= '0;
            port1_reg       <= '0;
            port2_reg       <= '0;
            status_reg      <= cfol_pkg::ST_OK;
            rd_hit_reg      <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            oldest_slot_reg <= oldest_slot_next;
            held_count_reg  <= held_count_next;
            dropped_reg     <= dropped_next;
            port1_reg       <= port1_next;
            port2_reg       <= port2_next;
            status_reg      <= status_next;
            rd_hit_reg      <= rd_hit_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The log never holds more frames than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= DEPTH_CNT)
        else $error("held count exceeds log depth");

    // The oldest pointer only moves once the log has filled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_slot_reg != '0) |-> is_full)
        else $error("oldest pointer moved before the log was full");

    // Frames are dropped only when an append finds the log full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dropped_reg != $past(dropped_reg)) |-> $past(is_full && append_ok))
        else $error("dropped counter changed without an overwrite");

    // An accepted request always moves on to its result cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RESULT))
        else $error("accepted request did not reach the result cycle");

    // A failed request never reports frame data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != cfol_pkg::ST_OK)) |->
        ((rsp_reg.rd_frame_id == '0) && (rsp_reg.rd_dlc == '0) &&
         (rsp_reg.rd_data_low == '0) && (rsp_reg.rd_data_high == '0)))
        else $error("failed request carries frame data");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN frame overwrite log: self-checking testbench
// A short scripted sequence covers rejected ports and length codes, the
// extreme field values and reads past the end of the log. Random requests
// then fill the ring, wrap it many times and read it back, under several
// mixes of sender gaps and receiver stalls. Every response is checked against
// its scripted result where one is given, else the testbench's own log predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LOG_SLOTS = 64;
    localparam int RANDOM_PER_PHASE = 360;
    localparam int LONG_HOLD = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 40;
    localparam int TIMEOUT_NS = 2_000_000;

    // Port codes that the block must reject.
    localparam logic [1:0] PORT_BAD_LOW  = 2'd2;
    localparam logic [1:0] PORT_BAD_HIGH = 2'd3;

    // One row of the scripted sequence; want is used only where typed is set.
    typedef struct {
        cfol_pkg::req_t rq;
        bit             typed;
        cfol_pkg::rsp_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    cfol_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    cfol_pkg::rsp_t rsp;

    // Predicted contents of the log.
    cfol_pkg::entry_t frame_log [LOG_SLOTS];
    logic [5:0]  oldest_pos = '0;
    logic [6:0]  held_frames = '0;
    logic [31:0] dropped_frames = '0;
    logic [31:0] port1_frames = '0;
    logic [31:0] port2_frames = '0;

    cfol_pkg::rsp_t pending_responses [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int sender_plan [4] = '{0, 70, 0, 29};
    int receiver_plan [4] = '{0, 0, 70, 29};
    logic hold_active = 1'b0;

    int mismatch_count = 0;
    int accepted_requests = 0;
    int checked_responses = 0;
    int frames_logged = 0;
    int frames_read = 0;
    int error_results = 0;
    int input_held_cycles = 0;

    can_frame_overwrite_log_unit #(
        .LOG_DEPTH(LOG_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one request to the predicted log and returns its response.
    function automatic cfol_pkg::rsp_t predict_log_response(input cfol_pkg::req_t rq);
        cfol_pkg::rsp_t res;
        logic [5:0]     slot;
        res = '0;
        res.status = cfol_pkg::ST_OK;
        if (rq.cmd == cfol_pkg::CMD_APPEND)
        begin
            if (rq.port != cfol_pkg::PORT_ONE && rq.port != cfol_pkg::PORT_TWO)
            begin
                res.status = cfol_pkg::ST_BAD_PORT;
            end
            else if (rq.dlc > cfol_pkg::DLC_LIMIT)
            begin
                res.status = cfol_pkg::ST_BAD_DLC;
            end
            else
            begin
                // A full log gives up its oldest slot to the new frame.
                if (held_frames == 7'(LOG_SLOTS))
                begin
                    slot = oldest_pos;
                    oldest_pos = oldest_pos + 6'd1;
                    dropped_frames = dropped_frames + 32'd1;
                end
                else
                begin
                    slot = oldest_pos + held_frames[5:0];
                    held_frames = held_frames + 7'd1;
                end
                frame_log[slot].port = rq.port[0];
                frame_log[slot].dlc = rq.dlc;
                frame_log[slot].extended = rq.extended;
                frame_log[slot].frame_id = rq.frame_id;
                frame_log[slot].data_high = rq.data_high;
                frame_log[slot].data_low = rq.data_low;
                if (rq.port == cfol_pkg::PORT_ONE)
                    port1_frames = port1_frames + 32'd1;
                else
                    port2_frames = port2_frames + 32'd1;
            end
        end
        else if (7'(rq.index) >= held_frames)
        begin
            res.status = cfol_pkg::ST_BAD_INDEX;
        end
        else
        begin
            slot = oldest_pos + rq.index;
            res.rd_port = frame_log[slot].port;
            res.rd_frame_id = frame_log[slot].frame_id;
            res.rd_extended = frame_log[slot].extended;
            res.rd_dlc = frame_log[slot].dlc;
            res.rd_data_low = frame_log[slot].data_low;
            res.rd_data_high = frame_log[slot].data_high;
        end
        res.entry_count = held_frames;
        res.dropped_total = dropped_frames;
        res.port1_total = port1_frames;
        res.port2_total = port2_frames;
        return res;
    endfunction

    function automatic cfol_pkg::req_t make_append(input logic [1:0] port,
                                                   input logic [28:0] frame_id,
                                                   input logic extended,
                                                   input logic [3:0] dlc,
                                                   input logic [31:0] data_low,
                                                   input logic [31:0] data_high);
        cfol_pkg::req_t rq;
        rq = '0;
        rq.cmd = cfol_pkg::CMD_APPEND;
        rq.port = port;
        rq.frame_id = frame_id;
        rq.extended = extended;
        rq.dlc = dlc;
        rq.data_low = data_low;
        rq.data_high = data_high;
        return rq;
    endfunction

    function automatic cfol_pkg::req_t make_read(input logic [1:0] port,
                                                 input logic [5:0] index);
        cfol_pkg::req_t rq;
        rq = '0;
        rq.cmd = cfol_pkg::CMD_READ;
        rq.port = port;
        rq.index = index;
        return rq;
    endfunction

    // Response with no frame attached; nothing has been dropped in the script.
    function automatic cfol_pkg::rsp_t totals_only(input logic [1:0] status,
                                                   input logic [6:0] count,
                                                   input logic [31:0] p1,
                                                   input logic [31:0] p2);
        cfol_pkg::rsp_t res;
        res = '0;
        res.status = status;
        res.entry_count = count;
        res.port1_total = p1;
        res.port2_total = p2;
        return res;
    endfunction

    // Good read of a frame that the script appended earlier.
    function automatic cfol_pkg::rsp_t stored_frame_view(input cfol_pkg::req_t frame,
                                                         input logic [6:0] count,
                                                         input logic [31:0] p1,
                                                         input logic [31:0] p2);
        cfol_pkg::rsp_t res;
        res = totals_only(cfol_pkg::ST_OK, count, p1, p2);
        res.rd_port = frame.port[0];
        res.rd_frame_id = frame.frame_id;
        res.rd_extended = frame.extended;
        res.rd_dlc = frame.dlc;
        res.rd_data_low = frame.data_low;
        res.rd_data_high = frame.data_high;
        return res;
    endfunction

    // Mostly well-formed appends and in-range reads, with some rejects mixed in.
    function automatic cfol_pkg::req_t draw_log_command();
        cfol_pkg::req_t rq;
        rq.cmd = ($urandom_range(99) < 55) ? cfol_pkg::CMD_APPEND : cfol_pkg::CMD_READ;
        if ($urandom_range(9) == 0)
            rq.port = 2'($urandom_range(int'(PORT_BAD_LOW), int'(PORT_BAD_HIGH)));
        else
            rq.port = 2'($urandom_range(int'(cfol_pkg::PORT_ONE),
                                        int'(cfol_pkg::PORT_TWO)));
        rq.frame_id = 29'($urandom);
        rq.extended = 1'($urandom);
        if ($urandom_range(9) == 0)
            rq.dlc = 4'($urandom_range(int'(cfol_pkg::DLC_LIMIT) + 1, 15));
        else
            rq.dlc = 4'($urandom_range(0, int'(cfol_pkg::DLC_LIMIT)));
        rq.data_low = $urandom;
        rq.data_high = $urandom;
        if (held_frames != 0 && $urandom_range(99) < 85)
            rq.index = 6'($urandom_range(int'(held_frames) - 1));
        else
            rq.index = 6'($urandom);
        return rq;
    endfunction

    task automatic report_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, text);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("response %0d field %s got %h expected %h",
                                      checked_responses, name, got, want));
    endtask

    // Compares one accepted response with the oldest predicted one.
    task automatic check_response(input cfol_pkg::rsp_t got);
        cfol_pkg::rsp_t want;
        if (pending_responses.size() == 0)
        begin
            report_mismatch("response arrived with no request outstanding");
        end
        else
        begin
            want = pending_responses.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("rd_port", 32'(got.rd_port), 32'(want.rd_port));
            compare_field("rd_frame_id", 32'(got.rd_frame_id), 32'(want.rd_frame_id));
            compare_field("rd_extended", 32'(got.rd_extended), 32'(want.rd_extended));
            compare_field("rd_dlc", 32'(got.rd_dlc), 32'(want.rd_dlc));
            compare_field("rd_data_low", got.rd_data_low, want.rd_data_low);
            compare_field("rd_data_high", got.rd_data_high, want.rd_data_high);
            compare_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
            compare_field("dropped_total", got.dropped_total, want.dropped_total);
            compare_field("port1_total", got.port1_total, want.port1_total);
            compare_field("port2_total", got.port2_total, want.port2_total);
        end
        checked_responses++;
    endtask

    // Offers one request, holding it until accepted, then records its expected response.
    task automatic send_request(input cfol_pkg::req_t rq, input bit typed,
                                input cfol_pkg::rsp_t want);
        cfol_pkg::rsp_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= rq;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_log_response(rq);
        pending_responses.push_back(typed ? want : predicted);
        accepted_requests++;
        if (predicted.status != cfol_pkg::ST_OK)
            error_results++;
        else if (rq.cmd == cfol_pkg::CMD_APPEND)
            frames_logged++;
        else
            frames_read++;
    endtask

    // Two long receiver hold-offs, each counted in cycles, back the block up
    // until it stalls its request input.
    initial
    begin
        wait (checked_responses >= 100);
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active <= 1'b0;
        wait (checked_responses >= 1200);
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Response side: checks every accepted response and drives random stalls,
    // held high throughout a long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_stall)
                input_held_cycles++;
            if (rsp_valid && !rsp_stall)
            begin
                check_response(rsp);
            end
            if (hold_active)
            begin
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Main sequence: reset, scripted requests, random phases, drain.
    initial
    begin
        script_row_t    script [$];
        cfol_pkg::req_t first_frame;
        cfol_pkg::req_t second_frame;
        cfol_pkg::rsp_t no_rsp;

        no_rsp = '0;
        first_frame = make_append(cfol_pkg::PORT_ONE, 29'h1FFF_FFFF, 1'b1,
                                  cfol_pkg::DLC_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        second_frame = make_append(cfol_pkg::PORT_TWO, 29'h0, 1'b0, 4'd0,
                                   32'hA5A5_A5A5, 32'h5A5A_5A5A);

        // Empty log, then every reject, with the port checked before the length.
        script.push_back('{make_read(cfol_pkg::PORT_ONE, 6'd0), 1'b1,
                           totals_only(cfol_pkg::ST_BAD_INDEX, 7'd0, 32'd0, 32'd0)});
        script.push_back('{make_append(PORT_BAD_LOW, 29'h155, 1'b0, 4'd3, 32'h1, 32'h2),
                           1'b1,
                           totals_only(cfol_pkg::ST_BAD_PORT, 7'd0, 32'd0, 32'd0)});
        script.push_back('{make_append(PORT_BAD_HIGH, 29'h1FFF_FFFF, 1'b1, 4'hF,
                                       32'hFFFF_FFFF, 32'hFFFF_FFFF),
                           1'b1,
                           totals_only(cfol_pkg::ST_BAD_PORT, 7'd0, 32'd0, 32'd0)});
        script.push_back('{make_append(cfol_pkg::PORT_ONE, 29'h7FF, 1'b0,
                                       cfol_pkg::DLC_LIMIT + 4'd1, 32'h0, 32'h0),
                           1'b1,
                           totals_only(cfol_pkg::ST_BAD_DLC, 7'd0, 32'd0, 32'd0)});
        script.push_back('{make_append(cfol_pkg::PORT_TWO, 29'h0, 1'b1, 4'hF,
                                       32'h0, 32'h0),
                           1'b1,
                           totals_only(cfol_pkg::ST_BAD_DLC, 7'd0, 32'd0, 32'd0)});
        // Two frames at the field extremes; bytes beyond the length are kept.
        script.push_back('{first_frame, 1'b1,
                           totals_only(cfol_pkg::ST_OK, 7'd1, 32'd1, 32'd0)});
        script.push_back('{second_frame, 1'b1,
                           totals_only(cfol_pkg::ST_OK, 7'd2, 32'd1, 32'd1)});
        // Reads ignore the port field.
        script.push_back('{make_read(PORT_BAD_HIGH, 6'd0), 1'b1,
                           stored_frame_view(first_frame, 7'd2, 32'd1, 32'd1)});
        script.push_back('{make_read(cfol_pkg::PORT_ONE, 6'd1), 1'b1,
                           stored_frame_view(second_frame, 7'd2, 32'd1, 32'd1)});
        script.push_back('{make_read(cfol_pkg::PORT_TWO, 6'd2), 1'b1,
                           totals_only(cfol_pkg::ST_BAD_INDEX, 7'd2, 32'd1, 32'd1)});
        script.push_back('{make_read(cfol_pkg::PORT_ONE, 6'd63), 1'b1,
                           totals_only(cfol_pkg::ST_BAD_INDEX, 7'd2, 32'd1, 32'd1)});
        script.push_back('{make_append(cfol_pkg::PORT_ONE, 29'h123, 1'b0, 4'd1,
                                       32'h0, 32'h8000_0000), 1'b0, no_rsp});
        script.push_back('{make_append(cfol_pkg::PORT_TWO, 29'h1000_0000, 1'b1, 4'd7,
                                       32'h1, 32'h0), 1'b0, no_rsp});
        script.push_back('{make_read(cfol_pkg::PORT_TWO, 6'd2), 1'b0, no_rsp});
        script.push_back('{make_read(cfol_pkg::PORT_ONE, 6'd3), 1'b0, no_rsp});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_request(script[i].rq, script[i].typed, script[i].want);

        // Random phases with different mixes of sender gaps and receiver stalls.
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = sender_plan[ph];
            receiver_stall_pct = receiver_plan[ph];
            repeat (RANDOM_PER_PHASE)
                send_request(draw_log_command(), 1'b0, no_rsp);
        end
        req_valid <= 1'b0;
        receiver_stall_pct = 0;

        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d frames logged, %0d overwritten, %0d good reads,",
                 accepted_requests, frames_logged, dropped_frames, frames_read);
        $display("%0d rejected requests; request input held off for %0d cycles.",
                 error_results, input_held_cycles);
        if (mismatch_count == 0 && pending_responses.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #TIMEOUT_NS;
        $display("Timed out with %0d responses outstanding.", pending_responses.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/cfol_pkg.sv
rtl/cfol_entry_ram.sv
rtl/can_frame_overwrite_log_unit.sv
test/testbench.sv
